// File: hdl/dcpid_pkg.sv
// shared types and constants for the dual channel pid block
`timescale 1ns / 1ps
package dcpid_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int CH_W         = 1;
  localparam int GAIN_W       = 16;
  localparam int ERR_W        = 18;
  localparam int INTEG_W      = 13;
  localparam int DELTA_W      = 19;
  localparam int DRIVE_W      = 26;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;
  localparam int Q_CNT_W      = 3;

  localparam int DEAD_BAND    = 40;
  localparam int SEPARATION   = 1500;
  localparam int INTEG_LIMIT  = 4000;

  localparam logic [CFG_ADDR_W-1:0] REG_KP0     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KI0     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KD0     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KP1     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KI1     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KD1     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET0 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET1 = 3'd7;

  typedef enum logic [1:0] {
    K_COMPUTE   = 2'd0,
    K_CLEAR_ONE = 2'd1,
    K_CLEAR_ALL = 2'd2,
    K_BAD       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CH_W-1:0]        ch;
    logic signed [ERR_W-1:0] err;
    logic                   dead;
    logic                   sep;
  } item_t;

endpackage

// File: hdl/dcpid_front.sv
// front end: target registers, request classification and error forming
`timescale 1ns / 1ps
module dcpid_front #(
  parameter int CHANNELS = dcpid_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dcpid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dcpid_pkg::GAIN_W-1:0]      cfg_wdata,
  input  logic                              op,
  input  logic [1:0]                        channel,
  input  logic signed [dcpid_pkg::GAIN_W-1:0] measured,
  output dcpid_pkg::item_t                  item
);

  logic signed [dcpid_pkg::GAIN_W-1:0] target_r [2];
  logic signed [dcpid_pkg::ERR_W-1:0]  tgt_ext;
  logic signed [dcpid_pkg::ERR_W-1:0]  meas_ext;
  logic signed [dcpid_pkg::ERR_W-1:0]  err;
  logic                                ch_valid;
  logic                                ch_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r[0] <= '0;
      target_r[1] <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == dcpid_pkg::REG_TARGET0) target_r[0] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_TARGET1) target_r[1] <= cfg_wdata;
    end
  end

  always_comb begin
    ch_valid = (channel < 2'(CHANNELS));
    ch_all   = (channel == 2'(CHANNELS));
    tgt_ext  = {{2{target_r[channel[0]][15]}}, target_r[channel[0]]};
    meas_ext = {{2{measured[15]}}, measured};
    err      = tgt_ext - meas_ext;

    item.ch   = channel[dcpid_pkg::CH_W-1:0];
    item.err  = err;
    item.dead = (err >= -18'sd40) && (err <= 18'sd40);
    item.sep  = (err > -18'sd1500) && (err < 18'sd1500);
    if (op) begin
      if (ch_valid)    item.kind = dcpid_pkg::K_CLEAR_ONE;
      else if (ch_all) item.kind = dcpid_pkg::K_CLEAR_ALL;
      else             item.kind = dcpid_pkg::K_BAD;
    end else begin
      item.kind = ch_valid ? dcpid_pkg::K_COMPUTE : dcpid_pkg::K_BAD;
    end
  end

endmodule

// File: hdl/dcpid_fifo.sv
// short request queue between front end and back end
`timescale 1ns / 1ps
module dcpid_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dcpid_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output dcpid_pkg::item_t head
);

  dcpid_pkg::item_t                    mem_r [dcpid_pkg::Q_DEPTH];
  logic [dcpid_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dcpid_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dcpid_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                do_push;
  logic                                do_pop;

  always_comb begin
    full       = (cnt_r == dcpid_pkg::Q_CNT_W'(dcpid_pkg::Q_DEPTH));
    not_empty  = (cnt_r != '0);
    head       = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && not_empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + dcpid_pkg::Q_CNT_W'(do_push) - dcpid_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hdl/dcpid_back.sv
// back end: channel state update, gain products, sum, shift and saturation
`timescale 1ns / 1ps
module dcpid_back #(
  parameter int CHANNELS = dcpid_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dcpid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dcpid_pkg::GAIN_W-1:0]      cfg_wdata,
  input  logic                              q_not_empty,
  input  dcpid_pkg::item_t                  q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dcpid_pkg::DRIVE_W-1:0] out_drive,
  output logic                              out_ok
);

  localparam int GW = dcpid_pkg::GAIN_W;
  localparam int EW = dcpid_pkg::ERR_W;
  localparam int IW = dcpid_pkg::INTEG_W;
  localparam int DW = dcpid_pkg::DELTA_W;

  logic signed [GW-1:0] kp_r [2];
  logic signed [GW-1:0] ki_r [2];
  logic signed [GW-1:0] kd_r [2];

  logic signed [IW-1:0] integ_r [CHANNELS];
  logic signed [EW-1:0] prev_r  [CHANNELS];

  logic en;

  // stage 1: error, integral and delta
  logic                            s1_v_r, s1_v_nxt;
  logic                            s1_ok_r, s1_ok_nxt;
  logic                            s1_cmp_r, s1_cmp_nxt;
  logic [dcpid_pkg::CH_W-1:0]      s1_ch_r, s1_ch_nxt;
  logic signed [EW-1:0]            s1_e_r, s1_e_nxt;
  logic signed [IW-1:0]            s1_i_r, s1_i_nxt;
  logic signed [DW-1:0]            s1_d_r, s1_d_nxt;

  // stage 2: products
  logic                            s2_v_r, s2_v_nxt;
  logic                            s2_ok_r, s2_ok_nxt;
  logic                            s2_cmp_r, s2_cmp_nxt;
  logic signed [33:0]              s2_p_r, s2_p_nxt;
  logic signed [28:0]              s2_i_r, s2_i_nxt;
  logic signed [34:0]              s2_d_r, s2_d_nxt;

  // output register
  logic                            out_v_r, out_v_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic signed [dcpid_pkg::DRIVE_W-1:0] out_drive_r, out_drive_nxt;

  logic signed [IW-1:0]            ibase;
  logic signed [IW:0]              isum;
  logic signed [IW-1:0]            iclamp;
  logic signed [35:0]              sum;
  logic signed [27:0]              shr;

  assign en        = !out_v_r || out_ready;
  assign q_pop     = en && q_not_empty;
  assign out_valid = out_v_r;
  assign out_drive = out_drive_r;
  assign out_ok    = out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r[0] <= '0; ki_r[0] <= '0; kd_r[0] <= '0;
      kp_r[1] <= '0; ki_r[1] <= '0; kd_r[1] <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == dcpid_pkg::REG_KP0) kp_r[0] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_KI0) ki_r[0] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_KD0) kd_r[0] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_KP1) kp_r[1] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_KI1) ki_r[1] <= cfg_wdata;
      if (cfg_addr == dcpid_pkg::REG_KD1) kd_r[1] <= cfg_wdata;
    end
  end

  always_comb begin
    s1_e_nxt   = q_head.dead ? '0 : q_head.err;
    ibase      = q_head.dead ? '0 : integ_r[q_head.ch];
    isum       = {ibase[IW-1], ibase} + s1_e_nxt[IW:0];
    if (isum > 14'sd4000)       iclamp = 13'sd4000;
    else if (isum < -14'sd4000) iclamp = -13'sd4000;
    else                        iclamp = isum[IW-1:0];
    s1_i_nxt   = q_head.sep ? iclamp : ibase;
    s1_d_nxt   = {s1_e_nxt[EW-1], s1_e_nxt} - {prev_r[q_head.ch][EW-1], prev_r[q_head.ch]};
    s1_ch_nxt  = q_head.ch;
    s1_v_nxt   = q_not_empty;
    s1_cmp_nxt = (q_head.kind == dcpid_pkg::K_COMPUTE);
    s1_ok_nxt  = (q_head.kind != dcpid_pkg::K_BAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        integ_r[c] <= '0;
        prev_r[c]  <= '0;
      end
    end else if (q_pop) begin
      case (q_head.kind)
        dcpid_pkg::K_COMPUTE: begin
          integ_r[q_head.ch] <= s1_i_nxt;
          prev_r[q_head.ch]  <= s1_e_nxt;
        end
        dcpid_pkg::K_CLEAR_ONE: begin
          integ_r[q_head.ch] <= '0;
          prev_r[q_head.ch]  <= '0;
        end
        dcpid_pkg::K_CLEAR_ALL: begin
          for (int c = 0; c < CHANNELS; c++) begin
            integ_r[c] <= '0;
            prev_r[c]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s2_v_nxt   = s1_v_r;
    s2_ok_nxt  = s1_ok_r;
    s2_cmp_nxt = s1_cmp_r;
    s2_p_nxt   = kp_r[s1_ch_r] * s1_e_r;
    s2_i_nxt   = ki_r[s1_ch_r] * s1_i_r;
    s2_d_nxt   = kd_r[s1_ch_r] * s1_d_r;
  end

  always_comb begin
    sum        = s2_p_r + s2_i_r + s2_d_r;
    shr        = sum[35:8];
    out_v_nxt  = s2_v_r;
    out_ok_nxt = s2_ok_r;
    if (!s2_cmp_r) begin
      out_drive_nxt = '0;
    end else if (shr[27:25] == 3'b000 || shr[27:25] == 3'b111) begin
      out_drive_nxt = shr[dcpid_pkg::DRIVE_W-1:0];
    end else if (shr[27]) begin
      out_drive_nxt = {1'b1, {(dcpid_pkg::DRIVE_W-1){1'b0}}};
    end else begin
      out_drive_nxt = {1'b0, {(dcpid_pkg::DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok_r     <= s1_ok_nxt;
      s1_cmp_r    <= s1_cmp_nxt;
      s1_ch_r     <= s1_ch_nxt;
      s1_e_r      <= s1_e_nxt;
      s1_i_r      <= s1_i_nxt;
      s1_d_r      <= s1_d_nxt;
      s2_ok_r     <= s2_ok_nxt;
      s2_cmp_r    <= s2_cmp_nxt;
      s2_p_r      <= s2_p_nxt;
      s2_i_r      <= s2_i_nxt;
      s2_d_r      <= s2_d_nxt;
      out_ok_r    <= out_ok_nxt;
      out_drive_r <= out_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

// File: hdl/dual_channel_pid_deadband_separation.sv
// top level of the two channel positional pid with deadband and integral separation
//
//  channel  direction  tdata / data                    tuser
//  in_      in         [1:0] channel, [17:2] measured  opcode
//  out_     out        [25:0] drive                    channel_ok
//  cfg_     in         wdata 16 bit, addr 0..7         -
//
//  one request per cycle while out_tready is high; a request passes the queue,
//  the state update stage, the gain multipliers, then sum and saturation
//  channel state is written at the pop, so requests on one channel follow back to back
//  rst_n is synchronous and clears gains, targets, channel state, queue and pipeline
//  a stalled result freezes the back end; the four entry queue takes requests until full
`timescale 1ns / 1ps
module dual_channel_pid_deadband_separation #(
  parameter int CHANNELS = dcpid_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dcpid_pkg::IN_DATA_W-1:0]      in_tdata,   // channel, measured
  input  logic                                 in_tuser,   // opcode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dcpid_pkg::OUT_DATA_W-1:0]     out_tdata,  // drive
  output logic                                 out_tuser,  // channel_ok
  input  logic                                 cfg_we,
  input  logic [dcpid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dcpid_pkg::GAIN_W-1:0]         cfg_wdata
);

  dcpid_pkg::item_t                       fe_item;
  dcpid_pkg::item_t                       q_head;
  logic                                   q_full;
  logic                                   q_not_empty;
  logic                                   q_pop;
  logic signed [dcpid_pkg::DRIVE_W-1:0]   drive;

  assign in_tready = !q_full;
  assign out_tdata = {{(dcpid_pkg::OUT_DATA_W-dcpid_pkg::DRIVE_W){1'b0}}, drive};

  dcpid_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .op        (in_tuser),
    .channel   (in_tdata[1:0]),
    .measured  (in_tdata[17:2]),
    .item      (fe_item)
  );

  dcpid_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (fe_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dcpid_back #(.CHANNELS(CHANNELS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_drive   (drive),
    .out_ok      (out_tuser)
  );

endmodule

// File: hdl/dcpid_check.sv
// port level checks for the dual channel pid block
`timescale 1ns / 1ps
module dcpid_check (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [dcpid_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dcpid_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                              out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("not ready right after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected request gave nonzero drive");

endmodule

bind dual_channel_pid_deadband_separation dcpid_check u_dcpid_check (.*);
